[rtl/core/nlc_pkg.sv]
`default_nettype none

package nlc_pkg;

   localparam int unsigned CountWidth   = 24;
   localparam int unsigned LfsrWidth    = 15;
   localparam int unsigned LevelWidth   = 4;
   localparam int unsigned ElapsedWidth = 16;
   localparam int unsigned CodeWidth    = 3;
   localparam int unsigned ShiftWidth   = 4;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned ShortTap     = 6;

   localparam logic [LfsrWidth-1:0] LfsrAllOnes = {LfsrWidth{1'b1}};

   localparam logic [1:0] RegDivisorCode = 2'd0;
   localparam logic [1:0] RegShortWidth  = 2'd1;
   localparam logic [1:0] RegPeriodShift = 2'd2;

   localparam logic CmdTick    = 1'b0;
   localparam logic CmdTrigger = 1'b1;

   typedef struct packed {
      logic [CodeWidth-1:0]  divisor_code;
      logic                  short_width_mode;
      logic [ShiftWidth-1:0] period_shift;
   } cfg_type;

   typedef struct packed {
      logic                    command;
      logic [ElapsedWidth-1:0] elapsed_cycles;
      logic                    channel_on;
      logic                    dac_enabled;
      logic [LevelWidth-1:0]   volume;
   } item_type;

   function automatic logic [LfsrWidth-1:0] lfsr_step(input logic [LfsrWidth-1:0] cur,
                                                      input logic short_mode);
      logic                 fb;
      logic [LfsrWidth-1:0] nxt;
      fb  = cur[0] ^ cur[1];
      nxt = {fb, cur[LfsrWidth-1:1]};
      if (short_mode) begin
         nxt[ShortTap] = fb;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

[rtl/core/nlc_csr.sv]
`default_nettype none

module nlc_csr
   import nlc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CsrAddrWidth-1:0] paddr,
   input  wire logic [CsrDataWidth-1:0] pwdata,
   output logic      [CsrDataWidth-1:0] prdata,
   output logic                         pready,
   output cfg_type                      cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[CsrAddrWidth-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            RegDivisorCode: cfg_in.divisor_code     = pwdata[CodeWidth-1:0];
            RegShortWidth:  cfg_in.short_width_mode = pwdata[0];
            RegPeriodShift: cfg_in.period_shift     = pwdata[ShiftWidth-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         RegDivisorCode: prdata[CodeWidth-1:0]  = cfg_ff.divisor_code;
         RegShortWidth:  prdata[0]              = cfg_ff.short_width_mode;
         RegPeriodShift: prdata[ShiftWidth-1:0] = cfg_ff.period_shift;
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/core/nlc_step.sv]
`default_nettype none

module nlc_step
   import nlc_pkg::*;
#(
   parameter int unsigned DIVISOR_STEP = 16
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire item_type              item,
   input  wire cfg_type               cfg,
   output logic      [LevelWidth-1:0] level,
   output logic                       stepped
);

   localparam int unsigned BaseMax   = DIVISOR_STEP * ((1 << CodeWidth) - 1);
   localparam int unsigned BaseWidth = $clog2(BaseMax + 1);
   localparam logic [BaseWidth-1:0] HalfStep = BaseWidth'(DIVISOR_STEP / 2);
   localparam logic [BaseWidth-1:0] StepVal  = BaseWidth'(DIVISOR_STEP);

   logic [CountWidth-1:0] period_count_ff, period_count_in;
   logic [LfsrWidth-1:0]  lfsr_ff, lfsr_in;
   logic [LevelWidth-1:0] held_level_ff, held_level_in;
   logic                  stepped_ff, stepped_in;

   logic [CountWidth-1:0] elapsed_ext;
   logic [BaseWidth-1:0]  base_div;
   logic [CountWidth-1:0] reload_val;
   logic [LfsrWidth-1:0]  lfsr_next;
   logic                  expire;

   assign elapsed_ext = CountWidth'(item.elapsed_cycles);
   assign expire      = elapsed_ext >= period_count_ff;

   always_comb begin
      if (cfg.divisor_code == '0) begin
         base_div = HalfStep;
      end else begin
         base_div = BaseWidth'(StepVal * BaseWidth'(cfg.divisor_code));
      end
   end

   assign reload_val = CountWidth'(base_div) << cfg.period_shift;
   assign lfsr_next  = lfsr_step(lfsr_ff, cfg.short_width_mode);

   always_comb begin
      period_count_in = period_count_ff;
      lfsr_in         = lfsr_ff;
      held_level_in   = held_level_ff;
      stepped_in      = stepped_ff;
      if (fire) begin
         stepped_in = 1'b0;
         priority if (item.command == CmdTrigger) begin
            lfsr_in = LfsrAllOnes;
         end else if (expire) begin
            period_count_in = reload_val;
            lfsr_in         = lfsr_next;
            held_level_in   = (item.channel_on && item.dac_enabled && !lfsr_next[0]) ?
                              item.volume : '0;
            stepped_in      = 1'b1;
         end else begin
            period_count_in = period_count_ff - elapsed_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff <= '0;
         lfsr_ff         <= '0;
         held_level_ff   <= '0;
         stepped_ff      <= 1'b0;
      end else begin
         period_count_ff <= period_count_in;
         lfsr_ff         <= lfsr_in;
         held_level_ff   <= held_level_in;
         stepped_ff      <= stepped_in;
      end
   end

   assign level   = held_level_ff;
   assign stepped = stepped_ff;

   a_trigger_fills: assert property (@(posedge clock) disable iff (reset)
      fire && item.command == CmdTrigger |=> lfsr_ff == LfsrAllOnes && !stepped_ff)
      else $error("trigger did not fill lfsr");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(period_count_ff) && $stable(lfsr_ff) && $stable(held_level_ff))
      else $error("state moved without a transfer");

   a_step_reloads: assert property (@(posedge clock) disable iff (reset)
      fire && item.command == CmdTick && expire |=>
         stepped_ff && period_count_ff == $past(reload_val))
      else $error("expiry did not reload period");

   a_trigger_keeps_level: assert property (@(posedge clock) disable iff (reset)
      fire && item.command == CmdTrigger |=> $stable(held_level_ff) && $stable(period_count_ff))
      else $error("trigger changed level or period");

endmodule

`default_nettype wire

[rtl/core/noise_lfsr_channel.sv]
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    command, elapsed_cycles, channel_on, dac_enabled, volume
// rsp      out        rsp_valid/stall    level, stepped
// csr      in         APB psel/penable   divisor_code @0x0, short_width_mode @0x4, period_shift @0x8
//
// One item per cycle sustained while rsp is not stalled; a transfer passes from req
// through the input register and then the state/result register to reach rsp.
// Synchronous reset clears config, period count, lfsr and level to zero.
// rsp stall backs up into the input register and then raises req_stall.
`default_nettype none

module noise_lfsr_channel
   import nlc_pkg::*;
#(
   parameter int unsigned DIVISOR_STEP = 16
)(
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_command,
   input  wire logic [ElapsedWidth-1:0] req_elapsed_cycles,
   input  wire logic                    req_channel_on,
   input  wire logic                    req_dac_enabled,
   input  wire logic [LevelWidth-1:0]   req_volume,

   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic      [LevelWidth-1:0]   rsp_level,
   output logic                         rsp_stepped,

   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [CsrDataWidth-1:0] csr_pwdata,
   output logic      [CsrDataWidth-1:0] csr_prdata,
   output logic                         csr_pready
);

   cfg_type  cfg;
   item_type item_ff, item_in;
   logic     in_vld_ff, in_vld_in;
   logic     out_vld_ff, out_vld_in;
   logic     out_free;
   logic     fire;
   logic     req_take;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign fire      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in = item_ff;
      if (req_take) begin
         item_in.command        = req_command;
         item_in.elapsed_cycles = req_elapsed_cycles;
         item_in.channel_on     = req_channel_on;
         item_in.dac_enabled    = req_dac_enabled;
         item_in.volume         = req_volume;
      end
   end

   assign in_vld_in  = req_take || (in_vld_ff && !fire);
   assign out_vld_in = fire || (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   nlc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   nlc_step #(
      .DIVISOR_STEP (DIVISOR_STEP)
   ) u_step (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (item_ff),
      .cfg     (cfg),
      .level   (rsp_level),
      .stepped (rsp_stepped)
   );

   assign rsp_valid = out_vld_ff;

endmodule

`default_nettype wire
